/* hw/rtl/walt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package walt_pkg;

	// Table geometry and field widths.
	localparam int SLOTS   = 15;
	localparam int BLOCK_W = 32;
	localparam int TAG_W   = 16;
	localparam int CNT_W   = 4;
	localparam int KIND_W  = 2;
	localparam int ACT_W   = 3;
	localparam int STS_W   = 3;

	// Input item kinds.
	localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// Result actions.
	localparam logic [ACT_W-1:0] ACT_STATUS  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_COPY    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ENTRY   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HEADER  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INSTALL = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAN   = 3'd5;

	// Status codes.
	localparam logic [STS_W-1:0] STS_OK_NEW = 3'd0;
	localparam logic [STS_W-1:0] STS_OK_DUP = 3'd1;
	localparam logic [STS_W-1:0] STS_NO_TXN = 3'd2;
	localparam logic [STS_W-1:0] STS_FULL   = 3'd3;
	localparam logic [STS_W-1:0] STS_BUSY   = 3'd4;

	// Commands broadcast to every cell of the slot chain.
	typedef struct packed {
		logic search;
		logic shift;
		logic append;
		logic update;
	} walt_ctl_t;

	// Per-cell position flags derived from the fill count.
	typedef struct packed {
		logic live;
		logic tail;
		logic fresh;
	} walt_slot_t;

endpackage

`default_nettype wire

/* hw/rtl/walt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module walt_cell
	import walt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire walt_ctl_t          ctl,
	input  wire walt_slot_t         slot,
	input  wire logic [BLOCK_W-1:0] find_blk,
	input  wire logic [BLOCK_W-1:0] key_blk,
	input  wire logic [TAG_W-1:0]   key_tag,
	input  wire logic [BLOCK_W-1:0] nxt_home,
	input  wire logic [TAG_W-1:0]   nxt_tag,
	input  wire logic [BLOCK_W-1:0] head_home,
	input  wire logic [TAG_W-1:0]   head_tag,
	output logic [BLOCK_W-1:0]      home,
	output logic [TAG_W-1:0]        tag,
	output logic                    hit
);

	logic [BLOCK_W-1:0] home_q;
	logic [TAG_W-1:0]   tag_q;
	logic               hit_q;

	// Match flag, captured when an item is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.search) begin
			hit_q <= slot.live && (home_q == find_blk);
		end
	end

	// Slot contents: rotate toward the head, append, or retag on a hit.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			home_q <= slot.tail ? head_home : nxt_home;
			tag_q  <= slot.tail ? head_tag : nxt_tag;
		end else if (ctl.append && slot.fresh) begin
			home_q <= key_blk;
			tag_q  <= key_tag;
		end else if (ctl.update && hit_q) begin
			tag_q <= key_tag;
		end
	end

	assign home = home_q;
	assign tag  = tag_q;
	assign hit  = hit_q;

endmodule

`default_nettype wire

/* hw/rtl/write_ahead_log_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Journal commit tracker.
// Input channel (in_valid/in_stall) carries kind, block_number and buffer_tag.
// Output channel (out_valid/out_stall) carries the results of each item:
// action, status, source_block, target_block, tag_out, count_or_index, last.
// log_base_block is written over the APB port at address 0; the user must do
// so only while idle, as the block does not enforce it. Begin, and any write
// or end that is rejected, gives one status result in the cycle after
// acceptance. A logged write takes two steps: the slot chain compares every
// slot with the block at acceptance, then the tag is replaced or the block
// appended. An end with n open slots gives 4n+2 results, one per cycle while
// out_stall is low; each copy, entry, install and clear-dirty result rotates
// the slot chain past its head cell once, and the two header writes leave it
// in place. One item is worked on at a time; in_stall stays high until it is
// done. A result waits in the output register while out_stall is high, and
// the whole sequence simply pauses. Reset closes any transaction, empties the
// table and clears log_base_block; no clearing pass is needed.
module write_ahead_log_tracker
	import walt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [BLOCK_W-1:0] block_number,
	input  wire logic [TAG_W-1:0]   buffer_tag,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [ACT_W-1:0]        action,
	output logic [STS_W-1:0]        status,
	output logic [BLOCK_W-1:0]      source_block,
	output logic [BLOCK_W-1:0]      target_block,
	output logic [TAG_W-1:0]        tag_out,
	output logic [CNT_W-1:0]        count_or_index,
	output logic                    last
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_COPY  = 3'd2;
	localparam logic [2:0] ST_ENTRY = 3'd3;
	localparam logic [2:0] ST_HDR   = 3'd4;
	localparam logic [2:0] ST_INST  = 3'd5;
	localparam logic [2:0] ST_HDR0  = 3'd6;
	localparam logic [2:0] ST_CLR   = 3'd7;

	localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

	logic [2:0]         state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic               txn_q, txn_d;
	logic [BLOCK_W-1:0] base_q;
	logic [BLOCK_W-1:0] key_blk_q;
	logic [TAG_W-1:0]   key_tag_q;

	logic               out_valid_q;
	logic [ACT_W-1:0]   action_q;
	logic [STS_W-1:0]   status_q;
	logic [BLOCK_W-1:0] src_q;
	logic [BLOCK_W-1:0] tgt_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_q;

	logic               emit;
	logic [ACT_W-1:0]   e_act;
	logic [STS_W-1:0]   e_sts;
	logic [BLOCK_W-1:0] e_src;
	logic [BLOCK_W-1:0] e_tgt;
	logic [TAG_W-1:0]   e_tag;
	logic [CNT_W-1:0]   e_cnt;
	logic               e_last;

	walt_ctl_t          ctl;
	logic               out_free;
	logic               in_acc;
	logic               phase_end;
	logic               hit_any;
	logic [BLOCK_W-1:0] slot_blk;

	logic [BLOCK_W-1:0] home_w [SLOTS];
	logic [TAG_W-1:0]   tag_w  [SLOTS];
	logic [SLOTS-1:0]   hit_vec;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			base_q <= pwdata;
		end
	end

	// Handshakes.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;

	// Slot chain: cell i takes from cell i+1, the tail cell from the head.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		walt_slot_t slot;
		assign slot.live  = (CNT_W'(i) < count_q);
		assign slot.tail  = (CNT_W'(i) == (count_q - CNT_W'(1)));
		assign slot.fresh = (CNT_W'(i) == count_q);

		walt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.slot      (slot),
			.find_blk  (block_number),
			.key_blk   (key_blk_q),
			.key_tag   (key_tag_q),
			.nxt_home  (home_w[(i + 1) % SLOTS]),
			.nxt_tag   (tag_w[(i + 1) % SLOTS]),
			.head_home (home_w[0]),
			.head_tag  (tag_w[0]),
			.home      (home_w[i]),
			.tag       (tag_w[i]),
			.hit       (hit_vec[i])
		);
	end

	assign hit_any   = |hit_vec;
	assign phase_end = (idx_q == (count_q - CNT_W'(1)));
	assign slot_blk  = base_q + BLOCK_W'(idx_q) + BLOCK_W'(1);

	// Sequencer: decides each result and drives the chain commands.
	always_comb begin
		emit    = 1'b0;
		e_act   = ACT_STATUS;
		e_sts   = STS_OK_NEW;
		e_src   = '0;
		e_tgt   = '0;
		e_tag   = '0;
		e_cnt   = '0;
		e_last  = 1'b0;
		state_d = state_q;
		idx_d   = idx_q;
		count_d = count_q;
		txn_d   = txn_q;
		ctl     = '0;
		ctl.search = in_acc;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_BEGIN: begin
							emit   = 1'b1;
							e_last = 1'b1;
							if (txn_q) begin
								e_sts = STS_BUSY;
							end else begin
								txn_d   = 1'b1;
								count_d = '0;
							end
						end
						KIND_WRITE: begin
							if (!txn_q) begin
								emit   = 1'b1;
								e_last = 1'b1;
								e_sts  = STS_NO_TXN;
							end else if (count_q == FULL) begin
								emit   = 1'b1;
								e_last = 1'b1;
								e_sts  = STS_FULL;
							end else begin
								state_d = ST_LOOK;
							end
						end
						KIND_END: begin
							if (!txn_q) begin
								emit   = 1'b1;
								e_last = 1'b1;
								e_sts  = STS_NO_TXN;
							end else begin
								idx_d   = '0;
								state_d = (count_q == '0) ? ST_HDR : ST_COPY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					emit    = 1'b1;
					e_last  = 1'b1;
					e_tag   = key_tag_q;
					state_d = ST_IDLE;
					if (hit_any) begin
						e_sts      = STS_OK_DUP;
						ctl.update = 1'b1;
					end else begin
						ctl.append = 1'b1;
						count_d    = count_q + CNT_W'(1);
					end
				end
			end
			ST_COPY: begin
				if (out_free) begin
					emit      = 1'b1;
					e_act     = ACT_COPY;
					e_tgt     = slot_blk;
					e_tag     = tag_w[0];
					ctl.shift = 1'b1;
					idx_d     = phase_end ? '0 : idx_q + CNT_W'(1);
					if (phase_end) begin
						state_d = ST_ENTRY;
					end
				end
			end
			ST_ENTRY: begin
				if (out_free) begin
					emit      = 1'b1;
					e_act     = ACT_ENTRY;
					e_tgt     = home_w[0];
					e_cnt     = idx_q;
					ctl.shift = 1'b1;
					idx_d     = phase_end ? '0 : idx_q + CNT_W'(1);
					if (phase_end) begin
						state_d = ST_HDR;
					end
				end
			end
			ST_HDR: begin
				if (out_free) begin
					emit    = 1'b1;
					e_act   = ACT_HEADER;
					e_tgt   = base_q;
					e_cnt   = count_q;
					idx_d   = '0;
					state_d = (count_q == '0) ? ST_HDR0 : ST_INST;
				end
			end
			ST_INST: begin
				if (out_free) begin
					emit      = 1'b1;
					e_act     = ACT_INSTALL;
					e_src     = slot_blk;
					e_tgt     = home_w[0];
					ctl.shift = 1'b1;
					idx_d     = phase_end ? '0 : idx_q + CNT_W'(1);
					if (phase_end) begin
						state_d = ST_HDR0;
					end
				end
			end
			ST_HDR0: begin
				if (out_free) begin
					emit  = 1'b1;
					e_act = ACT_HEADER;
					e_tgt = base_q;
					idx_d = '0;
					if (count_q == '0) begin
						e_last  = 1'b1;
						txn_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_CLR;
					end
				end
			end
			ST_CLR: begin
				if (out_free) begin
					emit      = 1'b1;
					e_act     = ACT_CLEAN;
					e_tag     = tag_w[0];
					ctl.shift = 1'b1;
					idx_d     = phase_end ? '0 : idx_q + CNT_W'(1);
					if (phase_end) begin
						e_last  = 1'b1;
						txn_d   = 1'b0;
						count_d = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			txn_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			txn_q   <= txn_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Write key and output payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_blk_q <= block_number;
			key_tag_q <= buffer_tag;
		end
		if (emit) begin
			action_q <= e_act;
			status_q <= e_sts;
			src_q    <= e_src;
			tgt_q    <= e_tgt;
			tag_q    <= e_tag;
			cnt_q    <= e_cnt;
			last_q   <= e_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign status         = status_q;
	assign source_block   = src_q;
	assign target_block   = tgt_q;
	assign tag_out        = tag_q;
	assign count_or_index = cnt_q;
	assign last           = last_q;

	// The fill count never passes the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("slot count beyond table size");

	// Outside a transaction the table is empty.
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!txn_q |-> (count_q == '0))
		else $error("slots held outside a transaction");

	// Blocks in the table are unique, so a lookup hits at most one cell.
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> $onehot0(hit_vec))
		else $error("block found in more than one slot");

	// An accepted write inside an open transaction with room goes to lookup.
	a_write_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (kind == KIND_WRITE) && txn_q && (count_q != FULL))
		|=> (state_q == ST_LOOK))
		else $error("write did not start a lookup");

endmodule

`default_nettype wire

/* bench/write_ahead_log_tracker_tb.sv */
`timescale 1ns / 1ps

module write_ahead_log_tracker_tb;
	import walt_pkg::*;

	// The one kind value that the tracker ignores.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	// Register index of log_base_block.
	localparam int REG_LOG_BASE = 0;
	localparam int TOTAL_ITEMS = 330;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT = 5000;

	// One result of the tracker, laid out field by field.
	typedef struct packed {
		logic [ACT_W-1:0]   act;
		logic [STS_W-1:0]   sts;
		logic [BLOCK_W-1:0] src;
		logic [BLOCK_W-1:0] dst;
		logic [TAG_W-1:0]   tag;
		logic [CNT_W-1:0]   cnt;
		logic               last;
	} journal_res_t;

	// One row of the directed plan. A typed row carries its single status result.
	typedef struct packed {
		logic               set_base;
		logic [BLOCK_W-1:0] base;
		logic [KIND_W-1:0]  op;
		logic [BLOCK_W-1:0] blk;
		logic [TAG_W-1:0]   tag;
		logic [4:0]         reps;
		logic               typed;
		logic [STS_W-1:0]   sts;
		logic [TAG_W-1:0]   etag;
	} plan_row_t;

	localparam int PLAN_ROWS = 13;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [KIND_W-1:0]  kind;
	logic [BLOCK_W-1:0] block_number;
	logic [TAG_W-1:0]   buffer_tag;
	logic               out_valid;
	logic               out_stall;
	logic [ACT_W-1:0]   action;
	logic [STS_W-1:0]   status;
	logic [BLOCK_W-1:0] source_block;
	logic [BLOCK_W-1:0] target_block;
	logic [TAG_W-1:0]   tag_out;
	logic [CNT_W-1:0]   count_or_index;
	logic               last;

	// Shadow copy of the journal state and the configuration.
	logic [BLOCK_W-1:0] log_base;
	logic               txn_open;
	int                 fill;
	logic [BLOCK_W-1:0] slot_home [SLOTS];
	logic [TAG_W-1:0]   slot_tag [SLOTS];

	journal_res_t step_buf [64];
	int           step_n;
	journal_res_t due_results [$];

	int   fault_count = 0;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	int   hold_left = 0;
	logic calm = 1'b0;
	logic hold_request = 1'b0;

	// Directed plan: error paths from reset, an empty commit, then a full table
	// with extreme blocks, a duplicate, an overflowing duplicate and a wrapping commit.
	plan_row_t plan [PLAN_ROWS] = '{
		'{1'b0, 32'h0, KIND_END, 32'h0, 16'h0, 5'd1, 1'b1, STS_NO_TXN, 16'h0},
		'{1'b0, 32'h0, KIND_WRITE, 32'h1234_5678, 16'hABCD, 5'd1, 1'b1, STS_NO_TXN, 16'h0},
		'{1'b0, 32'h0, KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b0, STS_OK_NEW, 16'h0},
		'{1'b0, 32'h0, KIND_BEGIN, 32'h0, 16'h0, 5'd1, 1'b1, STS_OK_NEW, 16'h0},
		'{1'b0, 32'h0, KIND_BEGIN, 32'h0, 16'h0, 5'd1, 1'b1, STS_BUSY, 16'h0},
		'{1'b0, 32'h0, KIND_END, 32'h0, 16'h0, 5'd1, 1'b0, STS_OK_NEW, 16'h0},
		'{1'b1, 32'hFFFF_FFF8, KIND_BEGIN, 32'h0, 16'h0, 5'd1, 1'b1, STS_OK_NEW, 16'h0},
		'{1'b0, 32'h0, KIND_WRITE, 32'h0, 16'h0, 5'd1, 1'b1, STS_OK_NEW, 16'h0},
		'{1'b0, 32'h0, KIND_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b1, STS_OK_NEW, 16'hFFFF},
		'{1'b0, 32'h0, KIND_WRITE, 32'h0, 16'h5A5A, 5'd1, 1'b1, STS_OK_DUP, 16'h5A5A},
		'{1'b0, 32'h0, KIND_WRITE, 32'h100, 16'h8000, 5'd13, 1'b0, STS_OK_NEW, 16'h0},
		'{1'b0, 32'h0, KIND_WRITE, 32'hFFFF_FFFF, 16'h0001, 5'd1, 1'b1, STS_FULL, 16'h0},
		'{1'b0, 32'h0, KIND_END, 32'h0, 16'h0, 5'd1, 1'b0, STS_OK_NEW, 16'h0}
	};

	write_ahead_log_tracker i_dut (.*);

	// Free-running clock, 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Appends one result, not yet marked last, to the step buffer.
	task automatic add_result(input logic [ACT_W-1:0] act, input logic [STS_W-1:0] sts,
			input logic [BLOCK_W-1:0] src, input logic [BLOCK_W-1:0] dst,
			input logic [TAG_W-1:0] tag, input logic [CNT_W-1:0] cnt);
		step_buf[step_n] = journal_res_t'{act, sts, src, dst, tag, cnt, 1'b0};
		step_n++;
	endtask

	// Works out the results of one accepted item and advances the shadow state.
	task automatic predict_journal(input logic [KIND_W-1:0] op, input logic [BLOCK_W-1:0] blk,
			input logic [TAG_W-1:0] tag);
		logic hit;
		int i;
		step_n = 0;
		hit = 1'b0;
		case (op)
			KIND_BEGIN: begin
				if (txn_open) begin
					add_result(ACT_STATUS, STS_BUSY, '0, '0, '0, '0);
				end else begin
					txn_open = 1'b1;
					fill = 0;
					add_result(ACT_STATUS, STS_OK_NEW, '0, '0, '0, '0);
				end
			end
			KIND_WRITE: begin
				if (!txn_open) begin
					add_result(ACT_STATUS, STS_NO_TXN, '0, '0, '0, '0);
				end else if (fill >= SLOTS) begin
					// The full check comes first, so even a duplicate overflows.
					add_result(ACT_STATUS, STS_FULL, '0, '0, '0, '0);
				end else begin
					for (i = 0; i < fill; i++) begin
						if (!hit && slot_home[i] == blk) begin
							hit = 1'b1;
							slot_tag[i] = tag;
						end
					end
					if (hit) begin
						add_result(ACT_STATUS, STS_OK_DUP, '0, '0, tag, '0);
					end else begin
						slot_home[fill] = blk;
						slot_tag[fill] = tag;
						fill++;
						add_result(ACT_STATUS, STS_OK_NEW, '0, '0, tag, '0);
					end
				end
			end
			KIND_END: begin
				if (!txn_open) begin
					add_result(ACT_STATUS, STS_NO_TXN, '0, '0, '0, '0);
				end else begin
					// Commit sequence; log slot addresses wrap at the block width.
					for (i = 0; i < fill; i++)
						add_result(ACT_COPY, STS_OK_NEW, '0, log_base + BLOCK_W'(i + 1),
							slot_tag[i], '0);
					for (i = 0; i < fill; i++)
						add_result(ACT_ENTRY, STS_OK_NEW, '0, slot_home[i], '0, CNT_W'(i));
					add_result(ACT_HEADER, STS_OK_NEW, '0, log_base, '0, CNT_W'(fill));
					for (i = 0; i < fill; i++)
						add_result(ACT_INSTALL, STS_OK_NEW, log_base + BLOCK_W'(i + 1),
							slot_home[i], '0, '0);
					add_result(ACT_HEADER, STS_OK_NEW, '0, log_base, '0, '0);
					for (i = 0; i < fill; i++)
						add_result(ACT_CLEAN, STS_OK_NEW, '0, '0, slot_tag[i], '0);
					fill = 0;
					txn_open = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fault_count++;
		end
	endfunction

	// Offers one item, holds it until accepted, then queues what it should cause.
	task automatic offer(input logic [KIND_W-1:0] op, input logic [BLOCK_W-1:0] blk,
			input logic [TAG_W-1:0] tag, input logic typed, input logic [STS_W-1:0] sts,
			input logic [TAG_W-1:0] etag);
		int j;
		if (!calm && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		block_number <= blk;
		buffer_tag <= tag;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_journal(op, blk, tag);
		if (typed) begin
			due_results.push_back(journal_res_t'{ACT_STATUS, sts, '0, '0, etag, '0, 1'b1});
		end else begin
			for (j = 0; j < step_n; j++) begin
				step_buf[j].last = (j == step_n - 1);
				due_results.push_back(step_buf[j]);
			end
		end
		if (op != KIND_UNUSED)
			items_sent++;
	endtask

	// Stops offering and waits until every expected result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes log_base_block over APB, then reads it back.
	task automatic program_base(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_LOG_BASE);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		log_base = value;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field("log_base_block", value, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: random stalls, a calm stretch, and one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 13);
		end
	end

	// Result checker and watchdog on cycles with no transaction anywhere.
	always @(posedge clk) begin : check_results
		journal_res_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_results.size() == 0) begin
				$error("result with nothing expected: action %0h status %0h", action, status);
				fault_count++;
			end else begin
				want = due_results.pop_front();
				check_field("action", 32'(want.act), 32'(action));
				check_field("status", 32'(want.sts), 32'(status));
				check_field("source_block", want.src, source_block);
				check_field("target_block", want.dst, target_block);
				check_field("tag_out", 32'(want.tag), 32'(tag_out));
				check_field("count_or_index", 32'(want.cnt), 32'(count_or_index));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
				|| (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: reset, the directed plan, then random journal transactions.
	initial begin : stimulus
		logic [BLOCK_W-1:0] used [32];
		logic [BLOCK_W-1:0] blk;
		logic [31:0]        value;
		int                 r;
		int                 j;
		int                 n;
		int                 nused;
		int                 phase;
		int                 next_cfg;
		logic               hold_done;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		kind = '0;
		block_number = '0;
		buffer_tag = '0;
		out_stall = 1'b0;
		log_base = '0;
		txn_open = 1'b0;
		fill = 0;
		phase = 0;
		next_cfg = 0;
		hold_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan.
		for (r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].set_base) begin
				drain();
				program_base(plan[r].base);
			end
			for (j = 0; j < plan[r].reps; j++)
				offer(plan[r].op, plan[r].blk + BLOCK_W'(j), plan[r].tag + TAG_W'(j),
					plan[r].typed, plan[r].sts, plan[r].etag);
		end

		// Random part: mostly whole transactions, some noise items.
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent >= next_cfg) begin
				drain();
				case (phase % 4)
					0: value = 32'hFFFF_FFFF;
					1: value = 32'h0;
					default: value = $urandom;
				endcase
				program_base(value);
				phase++;
				next_cfg = items_sent + 50;
			end
			calm = (items_sent >= 100 && items_sent < 170);
			if (!hold_done && items_sent >= 200) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 9) < 8) begin
				offer(KIND_BEGIN, $urandom, TAG_W'($urandom), 1'b0, STS_OK_NEW, '0);
				n = $urandom_range(0, 17);
				nused = 0;
				for (j = 0; j < n; j++) begin
					// Reuse earlier blocks now and then to hit the duplicate path.
					if (nused != 0 && $urandom_range(0, 3) == 0)
						blk = used[$urandom_range(0, nused - 1)];
					else if ($urandom_range(0, 2) == 0)
						blk = $urandom_range(0, 31);
					else
						blk = $urandom;
					if (nused < 32) begin
						used[nused] = blk;
						nused++;
					end
					offer(KIND_WRITE, blk, TAG_W'($urandom_range(0, 65535)), 1'b0,
						STS_OK_NEW, '0);
				end
				offer(KIND_END, $urandom, TAG_W'($urandom), 1'b0, STS_OK_NEW, '0);
			end else begin
				offer(KIND_W'($urandom_range(0, 3)), $urandom,
					TAG_W'($urandom_range(0, 65535)), 1'b0, STS_OK_NEW, '0);
			end
		end

		drain();
		if (due_results.size() == 0 && fault_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/walt_pkg.sv
hw/rtl/walt_cell.sv
hw/rtl/write_ahead_log_tracker.sv
bench/write_ahead_log_tracker_tb.sv
